FILE: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment lookup for the serial display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int unsigned VALUE_W   = 14;
  localparam int unsigned BCD_W     = 16;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned DIGITS    = 4;
  localparam int unsigned WORD_W    = SEG_W * DIGITS;
  localparam int unsigned BIT_CNT_W = 6;
  localparam int unsigned STEP_W    = 4;

  localparam logic [VALUE_W-1:0]   VALUE_MAX = 14'd9999;
  localparam logic [STEP_W-1:0]    LAST_STEP = 4'(VALUE_W - 1);
  localparam logic [SEG_W-1:0]     SEG_BLANK = 8'hFF;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT  = 6'd63;
  localparam logic [3:0]           FRAME_TOP = 4'hF;

  // front end state, one-hot
  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_CONV = 3'b010,
    FE_PUSH = 3'b100
  } fe_state_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // active-low segment code for one decimal digit
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Accepts a value, clamps it, converts to BCD one bit a cycle and pushes the
// four segment bytes (leading zeros blanked) into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ssd_pkg::VALUE_W-1:0]       in_value,
  input  wire ssd_pkg::q_stat_t                  q_stat,
  output logic                                   q_push,
  output logic [ssd_pkg::WORD_W-1:0]             q_wdata
);

  ssd_pkg::fe_state_t               state_r, state_nxt;
  logic [ssd_pkg::VALUE_W-1:0]      bin_r, bin_nxt;
  logic [ssd_pkg::BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [ssd_pkg::BCD_W-1:0]        adj;
  logic [ssd_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [3:0]                       d0, d1, d2, d3;
  logic                             blank3, blank2, blank1;

  // add-3 correction on every nibble ahead of the shift
  always_comb begin
    for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                               : bcd_r[4*i +: 4];
    end
  end

  assign d0 = bcd_r[3:0];
  assign d1 = bcd_r[7:4];
  assign d2 = bcd_r[11:8];
  assign d3 = bcd_r[15:12];
  assign blank3 = (d3 == 4'd0);
  assign blank2 = blank3 && (d2 == 4'd0);
  assign blank1 = blank2 && (d1 == 4'd0);

  assign q_wdata = {blank3 ? ssd_pkg::SEG_BLANK : ssd_pkg::seg_of(d3),
                    blank2 ? ssd_pkg::SEG_BLANK : ssd_pkg::seg_of(d2),
                    blank1 ? ssd_pkg::SEG_BLANK : ssd_pkg::seg_of(d1),
                    ssd_pkg::seg_of(d0)};

  assign busy   = (state_r != ssd_pkg::FE_IDLE);
  assign q_push = (state_r == ssd_pkg::FE_PUSH) && !q_stat.full;

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    step_nxt  = step_r;
    unique case (state_r)
      ssd_pkg::FE_IDLE: begin
        if (start) begin
          bin_nxt   = (in_value > ssd_pkg::VALUE_MAX) ? ssd_pkg::VALUE_MAX : in_value;
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ssd_pkg::FE_CONV;
        end
      end
      ssd_pkg::FE_CONV: begin
        bcd_nxt  = {adj[ssd_pkg::BCD_W-2:0], bin_r[ssd_pkg::VALUE_W-1]};
        bin_nxt  = {bin_r[ssd_pkg::VALUE_W-2:0], 1'b0};
        step_nxt = step_r + 4'd1;
        if (step_r == ssd_pkg::LAST_STEP) begin
          state_nxt = ssd_pkg::FE_PUSH;
        end
      end
      ssd_pkg::FE_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = ssd_pkg::FE_IDLE;
        end
      end
      default: state_nxt = ssd_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssd_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/ssd_queue.sv
// ----------------------------------------------------------------------------
// ssd_queue
// Two-entry queue of segment words between the front end and the serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_push,
  input  wire logic [ssd_pkg::WORD_W-1:0]    q_wdata,
  input  wire logic                          q_pop,
  output logic [ssd_pkg::WORD_W-1:0]         q_rdata,
  output ssd_pkg::q_stat_t                   q_stat
);

  logic [ssd_pkg::WORD_W-1:0] mem_r [2];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;

  assign q_rdata      = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ q_push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + 2'(q_push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Serialiser: four 16-bit frames per word, one bit a cycle, MSB first,
// units frame first; reloads on the last bit with no gap when the queue holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ssd_pkg::q_stat_t              q_stat,
  input  wire logic [ssd_pkg::WORD_W-1:0]    q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  output logic                               out_serial_bit,
  output logic                               out_frame_end,
  output logic                               out_last
);

  logic                              active_r, active_nxt;
  logic [ssd_pkg::BIT_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ssd_pkg::WORD_W-1:0]        word_r, word_nxt;
  logic [1:0]                        frame;
  logic [2:0]                        bit_pos;
  logic [ssd_pkg::SEG_W-1:0]         seg;
  logic                              at_last;

  assign frame   = cnt_r[5:4];
  assign bit_pos = ~cnt_r[2:0];  // bit index within the byte, 7 down to 0
  assign seg     = word_r[{frame, 3'b000} +: ssd_pkg::SEG_W];
  assign at_last = (cnt_r == ssd_pkg::LAST_BIT);

  assign out_valid      = active_r;
  // upper byte is the segment code, lower byte the one-hot digit select
  assign out_serial_bit = cnt_r[3] ? (bit_pos == {1'b0, frame}) : seg[bit_pos];
  assign out_frame_end  = active_r && (cnt_r[3:0] == ssd_pkg::FRAME_TOP);
  assign out_last       = active_r && at_last;

  assign q_pop = !q_stat.empty && (!active_r || at_last);

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    word_nxt   = word_r;
    if (q_pop) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      word_nxt   = q_rdata;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (at_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/seven_segment_serial_driver.sv
// A value is clamped, converted to BCD in 14 steps and pushed into the queue, then
// serialised; the one-bit-a-cycle serialiser sets the throughput. The front end
// waits to push while the queue is full and takes a new value once it has pushed;
// two converted values can wait in the queue.
// Each value gives 64 bit transactions on consecutive cycles; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue and idles both halves.
// ----------------------------------------------------------------------------
// seven_segment_serial_driver
// Four-digit seven-segment shift register driver: BCD front end, word queue
// and bit serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_driver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ssd_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_valid,
  output logic                               out_serial_bit,
  output logic                               out_frame_end,
  output logic                               out_last
);

  ssd_pkg::q_stat_t              q_stat;
  logic                          q_push;
  logic                          q_pop;
  logic [ssd_pkg::WORD_W-1:0]    q_wdata;
  logic [ssd_pkg::WORD_W-1:0]    q_rdata;

  ssd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  ssd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  ssd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_serial_bit (out_serial_bit),
    .out_frame_end  (out_frame_end),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_frame_end)
    else $error("last bit is not a frame end");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_last_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a 64-bit burst");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-digit serial display driver. Each accepted
// value is turned into its 64 expected shift bits (saturation, leading-zero
// blanking, segment and digit-select bytes), and every bit transaction on the
// output is compared against the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned FRAME_BITS   = 16;

  typedef logic [ssd_pkg::VALUE_W-1:0] value_t;
  typedef logic [ssd_pkg::SEG_W-1:0]   seg_t;

  // active-low segment codes, digits 0 to 9
  localparam seg_t DIGIT_SEGS [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic data;
    logic frame_end;
    logic last;
  } shift_bit_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  value_t             in_value;
  logic               out_valid;
  logic               out_serial_bit;
  logic               out_frame_end;
  logic               out_last;

  shift_bit_t  pending_bits [$];
  int unsigned idle_pct;
  int unsigned err_cnt;
  int unsigned values_sent;
  int unsigned saturated_cnt;
  int unsigned bits_checked;
  int unsigned quiet_cycles;

  seven_segment_serial_driver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_serial_bit(out_serial_bit),
    .out_frame_end (out_frame_end),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Builds the four frames for one value and queues their bits in shift order.
  function automatic void queue_display_bits(input value_t value);
    int unsigned v;
    int unsigned digit [4];
    seg_t seg [4];
    logic [15:0] frame;
    shift_bit_t sb;
    v = value;
    if (v > 9999) begin
      v = 9999;
      saturated_cnt++;
    end
    digit[3] = v / 1000;
    digit[2] = (v / 100) % 10;
    digit[1] = (v / 10) % 10;
    digit[0] = v % 10;
    for (int f = 0; f < 4; f++)
      seg[f] = DIGIT_SEGS[digit[f]];
    // blank leading zeros, never the units digit
    if (digit[3] == 0) begin
      seg[3] = ssd_pkg::SEG_BLANK;
      if (digit[2] == 0) begin
        seg[2] = ssd_pkg::SEG_BLANK;
        if (digit[1] == 0)
          seg[1] = ssd_pkg::SEG_BLANK;
      end
    end
    for (int f = 0; f < 4; f++) begin
      frame = {seg[f], 8'(1 << f)};
      for (int b = FRAME_BITS - 1; b >= 0; b--) begin
        sb.data      = frame[b];
        sb.frame_end = (b == 0);
        sb.last      = (b == 0) && (f == 3);
        pending_bits.push_back(sb);
      end
    end
  endfunction

  // Sends one value; start is left high after the transaction so a following
  // value can go straight in.
  task automatic send_value(input value_t value);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    do
      @(posedge clk);
    while (busy);
    queue_display_bits(value);
    values_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_bits.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic value_t random_value();
    case ($urandom_range(9))
      0, 1:    return value_t'($urandom_range(9));
      2, 3:    return value_t'($urandom_range(99));
      4:       return value_t'($urandom_range(999));
      5, 6:    return value_t'($urandom_range(9999));
      7:       return value_t'($urandom_range(16383, 10000));
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic test_directed_values();
    value_t vals [$];
    vals = '{0, 7, 10, 99, 100, 305, 999, 1000, 1001, 4060, 1234, 5678, 8890,
             9999, 10000, 16383, 14'h2AAA, 14'h1555};
    idle_pct = 6;
    foreach (vals[i])
      send_value(vals[i]);
    wait_drained();
  endtask

  task automatic test_random_values(input int unsigned count);
    idle_pct = 6;
    repeat (count) begin
      // now and then pause with start low so the queue and serialiser can drain before the next one
      if ($urandom_range(49) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(150, 60)) @(posedge clk);
      end
      send_value(random_value());
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_pct = 0;
    repeat (count)
      send_value(random_value());
    wait_drained();
  endtask

  // Checks every bit transaction and keeps the watchdog.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb failed");
      $finish;
    end else if (rst_n && out_valid) begin
      if (pending_bits.size() == 0) begin
        $error("unexpected bit transaction: data %0b frame_end %0b last %0b",
               out_serial_bit, out_frame_end, out_last);
        err_cnt++;
      end else begin
        shift_bit_t exp_bit;
        exp_bit = pending_bits.pop_front();
        bits_checked++;
        if (out_serial_bit !== exp_bit.data) begin
          $error("out_serial_bit: expected %0b, got %0b", exp_bit.data, out_serial_bit);
          err_cnt++;
        end
        if (out_frame_end !== exp_bit.frame_end) begin
          $error("out_frame_end: expected %0b, got %0b", exp_bit.frame_end, out_frame_end);
          err_cnt++;
        end
        if (out_last !== exp_bit.last) begin
          $error("out_last: expected %0b, got %0b", exp_bit.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_value      = '0;
    idle_pct      = 6;
    err_cnt       = 0;
    values_sent   = 0;
    saturated_cnt = 0;
    bits_checked  = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_random_values(230);
    test_back_to_back(100);
    wait_drained();

    $display("covered %0d values (%0d saturated), %0d shift bits checked",
             values_sent, saturated_cnt, bits_checked);
    $display("directed digit and blanking cases, random values, back-to-back load");
    if (err_cnt == 0 && pending_bits.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_back.sv
rtl/seven_segment_serial_driver.sv
tb/sv/tb.sv
